@@ rtl/mrs_pkg.sv @@
// ----------------------------------------------------------------------------
// mrs_pkg
// Shared types, constants and functions of the Modbus RTU slave responder.
// ----------------------------------------------------------------------------
`default_nettype none

package mrs_pkg;

	// Default sizing
	localparam int READ_REGS_DEF     = 24;
	localparam int HOLD_REGS_DEF     = 8;
	localparam int FRAME_BYTES_DEF   = 64;
	localparam int MIRROR_OFFSET_DEF = 10;

	// Configuration register indexes
	localparam logic [1:0] CFG_SLAVE_ADDR = 2'd0;
	localparam logic [1:0] CFG_READ_BASE  = 2'd1;
	localparam logic [1:0] CFG_HOLD_BASE  = 2'd2;

	// Function codes
	localparam logic [7:0] FN_READ_COILS  = 8'h01;
	localparam logic [7:0] FN_READ_HOLD   = 8'h03;
	localparam logic [7:0] FN_WRITE_COIL  = 8'h05;
	localparam logic [7:0] FN_WRITE_ONE   = 8'h06;
	localparam logic [7:0] FN_WRITE_COILS = 8'h0F;
	localparam logic [7:0] FN_WRITE_MULTI = 8'h10;
	localparam logic [7:0] FN_EXC_FLAG    = 8'h80;

	// Exception codes
	localparam logic [1:0] EXC_FUNC  = 2'd1;
	localparam logic [1:0] EXC_ADDR  = 2'd2;
	localparam logic [1:0] EXC_VALUE = 2'd3;

	// CRC-16/MODBUS
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	typedef enum logic [1:0] {
		MODE_EXC,
		MODE_READ,
		MODE_WRITE
	} mode_t;

	typedef enum logic [2:0] {
		S_COLLECT,
		S_DECODE,
		S_RD_HI,
		S_RD_LO,
		S_RD_USE,
		S_MIRROR,
		S_EMIT
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic       clr_frame;
		logic       start_emit;
		mode_t      mode;
		logic [1:0] exc_code;
		logic       wr06;
		logic       wr10;
		logic       mirror;
		logic       wcnt_clr;
		logic       wcnt_inc;
		logic       rd_hi;
		logic       rd_lo;
		logic       emit_step;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic       frame_end;
		logic       short_frame;
		logic [7:0] func;
		logic       rd_bad;
		logic       h6_bad;
		logic       h10_bad;
		logic       qty_b15;
		logic       bc_bad;
		logic       word_b15;
		logic       last_word;
		logic       emit_last;
		logic       out_free;
	} status_t;

	// One byte through the reflected CRC (eight bit steps)
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
		logic [15:0] c;
		c = crc ^ {8'h00, data};
		for (int b = 0; b < 8; b++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

@@ rtl/mrs_if.sv @@
// ----------------------------------------------------------------------------
// mrs_if
// Valid/ready channels: request beats in, response beats out.
// ----------------------------------------------------------------------------
`default_nettype none

interface mrs_req_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [7:0]  rx_byte;
	logic        rx_last;
	logic [4:0]  load_index;
	logic [15:0] load_value;

	modport source (output valid, command, rx_byte, rx_last, load_index, load_value,
		input ready);
	modport sink (input valid, command, rx_byte, rx_last, load_index, load_value,
		output ready);
endinterface

interface mrs_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] tx_byte;
	logic       tx_last;
	logic       regs_written;

	modport source (output valid, tx_byte, tx_last, regs_written, input ready);
	modport sink (input valid, tx_byte, tx_last, regs_written, output ready);
endinterface

`default_nettype wire

@@ rtl/mrs_ram.sv @@
// ----------------------------------------------------------------------------
// mrs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mrs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ rtl/mrs_dp.sv @@
// ----------------------------------------------------------------------------
// mrs_dp
// Datapath: frame buffer, header capture, stores, decode checks and
// response byte generation with running CRC.
// ----------------------------------------------------------------------------
`default_nettype none

module mrs_dp
	import mrs_pkg::*;
#(
	parameter int READ_REGS     = READ_REGS_DEF,
	parameter int HOLD_REGS     = HOLD_REGS_DEF,
	parameter int FRAME_BYTES   = FRAME_BYTES_DEF,
	parameter int MIRROR_OFFSET = MIRROR_OFFSET_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cmd_t        cmd,
	output status_t          st,
	input  wire logic        in_acc,
	input  wire logic        command,
	input  wire logic [7:0]  rx_byte,
	input  wire logic        rx_last,
	input  wire logic [4:0]  load_index,
	input  wire logic [15:0] load_value,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_wdata,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       tx_byte,
	output logic             tx_last,
	output logic             regs_written
);

	localparam int LEN_W = $clog2(FRAME_BYTES + 1);
	localparam int AW    = $clog2(FRAME_BYTES);
	localparam int WC_W  = $clog2(HOLD_REGS + 1);
	localparam int HI_W  = (HOLD_REGS > 1) ? $clog2(HOLD_REGS) : 1;
	localparam int RI_W  = $clog2(READ_REGS);
	localparam int PW    = $clog2(5 + 2 * READ_REGS + 1);

	// Configuration
	logic [7:0]  slave_addr_q;
	logic [15:0] read_base_q;
	logic [15:0] hold_base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_addr_q <= 8'h01;
			read_base_q  <= '0;
			hold_base_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SLAVE_ADDR: slave_addr_q <= cfg_wdata[7:0];
				CFG_READ_BASE:  read_base_q  <= cfg_wdata;
				CFG_HOLD_BASE:  hold_base_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Frame collection and header capture
	logic [LEN_W-1:0] len_q;
	logic [7:0] func_q, start_hi_q, start_lo_q, qty_hi_q, qty_lo_q, bc_q;
	logic acc_req;
	logic len_room;

	assign acc_req  = in_acc && !command;
	assign len_room = len_q < LEN_W'(FRAME_BYTES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= '0;
			func_q     <= '0;
			start_hi_q <= '0;
			start_lo_q <= '0;
			qty_hi_q   <= '0;
			qty_lo_q   <= '0;
			bc_q       <= '0;
		end else if (cmd.clr_frame) begin
			len_q      <= '0;
			func_q     <= '0;
			start_hi_q <= '0;
			start_lo_q <= '0;
			qty_hi_q   <= '0;
			qty_lo_q   <= '0;
			bc_q       <= '0;
		end else if (acc_req && len_room) begin
			len_q <= len_q + 1'b1;
			case (len_q)
				LEN_W'(1): func_q     <= rx_byte;
				LEN_W'(2): start_hi_q <= rx_byte;
				LEN_W'(3): start_lo_q <= rx_byte;
				LEN_W'(4): qty_hi_q   <= rx_byte;
				LEN_W'(5): qty_lo_q   <= rx_byte;
				LEN_W'(6): bc_q       <= rx_byte;
				default: ;
			endcase
		end
	end

	// Frame buffer read for the data words of a multi-write
	logic [WC_W-1:0]  wcnt_q;
	logic [LEN_W-1:0] ridx;
	logic [7:0]       rdata;
	logic             ok_q;
	logic [7:0]       hi_q;
	logic [7:0]       lo_c;
	logic [15:0]      word_c;

	assign ridx = LEN_W'(7) + (LEN_W'(wcnt_q) << 1) + LEN_W'(cmd.rd_lo);

	mrs_ram #(
		.WIDTH(8),
		.DEPTH(FRAME_BYTES)
	) u_frame_ram (
		.clk  (clk),
		.we   (acc_req && len_room),
		.waddr(len_q[AW-1:0]),
		.wdata(rx_byte),
		.raddr(ridx[AW-1:0]),
		.rdata(rdata)
	);

	// Bytes past the frame end read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q   <= 1'b0;
			hi_q   <= '0;
			wcnt_q <= '0;
		end else begin
			if (cmd.rd_hi || cmd.rd_lo) begin
				ok_q <= ridx < len_q;
			end
			if (cmd.rd_lo) begin
				hi_q <= ok_q ? rdata : 8'h00;
			end
			if (cmd.wcnt_clr) begin
				wcnt_q <= '0;
			end else if (cmd.wcnt_inc) begin
				wcnt_q <= wcnt_q + 1'b1;
			end
		end
	end

	assign lo_c   = ok_q ? rdata : 8'h00;
	assign word_c = {hi_q, lo_c};

	// Range checks
	logic [15:0] start_c, qty_c;
	logic [16:0] rd_diff, rd_sum, h_diff, h_sum;

	assign start_c = {start_hi_q, start_lo_q};
	assign qty_c   = {qty_hi_q, qty_lo_q};
	assign rd_diff = {1'b0, start_c} - {1'b0, read_base_q};
	assign rd_sum  = {1'b0, rd_diff[15:0]} + {1'b0, qty_c};
	assign h_diff  = {1'b0, start_c} - {1'b0, hold_base_q};
	assign h_sum   = {1'b0, h_diff[15:0]} + {1'b0, qty_c};

	// Holding store and read store
	logic [15:0]     hold_q [HOLD_REGS];
	logic [15:0]     rstore_q [READ_REGS];
	logic [HI_W-1:0] hidx;

	assign hidx = HI_W'(h_diff[15:0] + 16'(wcnt_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HOLD_REGS; i++) begin
				hold_q[i] <= '0;
			end
		end else if (cmd.wr06) begin
			hold_q[HI_W'(h_diff[15:0])] <= qty_c;
		end else if (cmd.wr10) begin
			hold_q[hidx] <= word_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < READ_REGS; i++) begin
				rstore_q[i] <= '0;
			end
		end else if (in_acc && command) begin
			if (load_index < 5'(READ_REGS)) begin
				rstore_q[load_index[RI_W-1:0]] <= load_value;
			end
		end else if (cmd.mirror) begin
			// copy the whole holding store, dropping words past the end
			for (int i = 0; i < HOLD_REGS; i++) begin
				if (MIRROR_OFFSET + i < READ_REGS) begin
					rstore_q[MIRROR_OFFSET + i] <= hold_q[i];
				end
			end
		end
	end

	// Response generation
	mode_t       mode_q;
	logic [1:0]  code_q;
	logic [PW-1:0] pos_q;
	logic [15:0] crc_q;
	logic [PW-1:0] body_len;
	logic [PW-1:0] rel;
	logic [RI_W-1:0] rs_idx;
	logic [15:0] rs_word;
	logic [7:0]  byte_c;
	logic        in_body;
	logic        out_free;

	always_comb begin
		case (mode_q)
			MODE_READ:  body_len = PW'(3) + PW'({qty_c, 1'b0});
			MODE_WRITE: body_len = PW'(6);
			default:    body_len = PW'(3);
		endcase
	end

	assign rel     = pos_q - PW'(3);
	assign rs_idx  = RI_W'(rd_diff[15:0]) + RI_W'(rel >> 1);
	assign rs_word = rstore_q[rs_idx];
	assign in_body = pos_q < body_len;

	always_comb begin
		byte_c = 8'h00;
		if (!in_body) begin
			byte_c = (pos_q == body_len) ? crc_q[7:0] : crc_q[15:8];
		end else begin
			case (pos_q)
				PW'(0): byte_c = slave_addr_q;
				PW'(1): byte_c = (mode_q == MODE_EXC) ? (func_q | FN_EXC_FLAG) : func_q;
				PW'(2): begin
					case (mode_q)
						MODE_EXC:  byte_c = {6'd0, code_q};
						MODE_READ: byte_c = {qty_lo_q[6:0], 1'b0};
						default:   byte_c = start_hi_q;
					endcase
				end
				default: begin
					if (mode_q == MODE_READ) begin
						byte_c = rel[0] ? rs_word[7:0] : rs_word[15:8];
					end else begin
						case (pos_q)
							PW'(3):  byte_c = start_lo_q;
							PW'(4):  byte_c = qty_hi_q;
							default: byte_c = qty_lo_q;
						endcase
					end
				end
			endcase
		end
	end

	assign out_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_EXC;
			code_q    <= '0;
			pos_q     <= '0;
			crc_q     <= CRC_INIT;
			out_valid <= 1'b0;
		end else begin
			if (cmd.start_emit) begin
				mode_q <= cmd.mode;
				code_q <= cmd.exc_code;
				pos_q  <= '0;
				crc_q  <= CRC_INIT;
			end else if (cmd.emit_step) begin
				pos_q <= pos_q + 1'b1;
				if (in_body) begin
					crc_q <= crc_byte(crc_q, byte_c);
				end
			end
			if (cmd.emit_step) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (cmd.emit_step) begin
			tx_byte      <= byte_c;
			tx_last      <= st.emit_last;
			regs_written <= mode_q == MODE_WRITE;
		end
	end

	// Status to controller
	always_comb begin
		st.frame_end   = acc_req && rx_last;
		st.short_frame = len_q < LEN_W'(4);
		st.func        = func_q;
		st.rd_bad      = (qty_c == '0) || rd_diff[16] || (rd_sum > 17'(READ_REGS));
		st.h6_bad      = h_diff[16] || (h_diff[15:0] >= 16'(HOLD_REGS));
		st.h10_bad     = (qty_c == '0) || h_diff[16] || (h_sum > 17'(HOLD_REGS));
		st.qty_b15     = qty_c[15];
		st.bc_bad      = {9'd0, bc_q} != {qty_c, 1'b0};
		st.word_b15    = word_c[15];
		st.last_word   = (17'(wcnt_q) + 17'd1) == {1'b0, qty_c};
		st.emit_last   = pos_q == (body_len + 1'b1);
		st.out_free    = out_free;
	end

endmodule

`default_nettype wire

@@ rtl/mrs_ctrl.sv @@
// ----------------------------------------------------------------------------
// mrs_ctrl
// Controller: collects a frame, decodes it, runs the write checks and
// sequences the response beats.
// ----------------------------------------------------------------------------
`default_nettype none

module mrs_ctrl
	import mrs_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire status_t st,
	output cmd_t         cmd,
	output logic         in_ready
);

	state_t state_q, state_d;
	logic   wphase_q, wphase_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_COLLECT;
			wphase_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			wphase_q <= wphase_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		wphase_d = wphase_q;
		cmd      = '0;
		cmd.mode = MODE_EXC;
		in_ready = 1'b0;

		case (state_q)
			S_COLLECT: begin
				in_ready = 1'b1;
				if (st.frame_end) begin
					state_d = S_DECODE;
				end
			end

			S_DECODE: begin
				state_d = S_EMIT;
				cmd.start_emit = 1'b1;
				if (st.short_frame) begin
					cmd.start_emit = 1'b0;
					cmd.clr_frame  = 1'b1;
					state_d        = S_COLLECT;
				end else begin
					case (st.func)
						FN_READ_COILS, FN_WRITE_COIL, FN_WRITE_COILS: begin
							cmd.start_emit = 1'b0;
							cmd.clr_frame  = 1'b1;
							state_d        = S_COLLECT;
						end
						FN_READ_HOLD: begin
							if (st.rd_bad) begin
								cmd.exc_code = EXC_ADDR;
							end else begin
								cmd.mode = MODE_READ;
							end
						end
						FN_WRITE_ONE: begin
							if (st.h6_bad) begin
								cmd.exc_code = EXC_ADDR;
							end else if (st.qty_b15) begin
								cmd.exc_code = EXC_VALUE;
							end else begin
								cmd.start_emit = 1'b0;
								cmd.wr06       = 1'b1;
								state_d        = S_MIRROR;
							end
						end
						FN_WRITE_MULTI: begin
							if (st.h10_bad) begin
								cmd.exc_code = EXC_ADDR;
							end else if (st.bc_bad) begin
								cmd.exc_code = EXC_VALUE;
							end else begin
								cmd.start_emit = 1'b0;
								cmd.wcnt_clr   = 1'b1;
								wphase_d       = 1'b0;
								state_d        = S_RD_HI;
							end
						end
						default: cmd.exc_code = EXC_FUNC;
					endcase
				end
			end

			S_RD_HI: begin
				cmd.rd_hi = 1'b1;
				state_d   = S_RD_LO;
			end

			S_RD_LO: begin
				cmd.rd_lo = 1'b1;
				state_d   = S_RD_USE;
			end

			// Check pass over all words first, then the write pass
			S_RD_USE: begin
				if (!wphase_q) begin
					if (st.word_b15) begin
						cmd.start_emit = 1'b1;
						cmd.exc_code   = EXC_VALUE;
						state_d        = S_EMIT;
					end else if (st.last_word) begin
						cmd.wcnt_clr = 1'b1;
						wphase_d     = 1'b1;
						state_d      = S_RD_HI;
					end else begin
						cmd.wcnt_inc = 1'b1;
						state_d      = S_RD_HI;
					end
				end else begin
					cmd.wr10 = 1'b1;
					if (st.last_word) begin
						state_d = S_MIRROR;
					end else begin
						cmd.wcnt_inc = 1'b1;
						state_d      = S_RD_HI;
					end
				end
			end

			S_MIRROR: begin
				cmd.mirror     = 1'b1;
				cmd.start_emit = 1'b1;
				cmd.mode       = MODE_WRITE;
				state_d        = S_EMIT;
			end

			S_EMIT: begin
				if (st.out_free) begin
					cmd.emit_step = 1'b1;
					if (st.emit_last) begin
						cmd.clr_frame = 1'b1;
						state_d       = S_COLLECT;
					end
				end
			end

			default: state_d = S_COLLECT;
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/modbus_rtu_slave_responder_top.sv @@
// ----------------------------------------------------------------------------
// modbus_rtu_slave_responder_top
// Modbus RTU slave responder: request frames in, response frames out.
// ----------------------------------------------------------------------------
// Usage:
//   req carries request bytes (command 0, rx_last on the final byte of a
//   frame) and read-store loads (command 1). rsp carries response bytes,
//   tx_last on the final one, ending in CRC-16/MODBUS low byte first.
//   cfg_we/cfg_index/cfg_wdata write slave address, read base, hold base.
// Timing:
//   Request bytes and loads are taken while req is ready. After the last
//   byte the frame is decoded in S_DECODE. Function 10 then walks its data
//   words through the frame buffer RAM in S_RD_HI, S_RD_LO and S_RD_USE,
//   twice (check, then write; a value exception ends the check pass), and
//   functions 06 and 10 then mirror the holding store. Response bytes then
//   leave one per cycle while rsp is ready. req is held off from the last
//   request byte until the final response byte, if any, is in the output
//   register.
// Reset: stores and frame length clear, slave address is 1, bases are 0;
//   the frame buffer needs no clearing. A stalled receiver holds the
//   current beat and the byte sequencer waits.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_rtu_slave_responder_top
	import mrs_pkg::*;
#(
	parameter int READ_REGS     = READ_REGS_DEF,
	parameter int HOLD_REGS     = HOLD_REGS_DEF,
	parameter int FRAME_BYTES   = FRAME_BYTES_DEF,
	parameter int MIRROR_OFFSET = MIRROR_OFFSET_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	mrs_req_if.sink          req,
	mrs_rsp_if.source        rsp,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_wdata
);

	cmd_t    cmd;
	status_t st;
	logic    in_ready;

	assign req.ready = in_ready;

	mrs_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.st      (st),
		.cmd     (cmd),
		.in_ready(in_ready)
	);

	mrs_dp #(
		.READ_REGS    (READ_REGS),
		.HOLD_REGS    (HOLD_REGS),
		.FRAME_BYTES  (FRAME_BYTES),
		.MIRROR_OFFSET(MIRROR_OFFSET)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.in_acc      (req.valid && in_ready),
		.command     (req.command),
		.rx_byte     (req.rx_byte),
		.rx_last     (req.rx_last),
		.load_index  (req.load_index),
		.load_value  (req.load_value),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.out_valid   (rsp.valid),
		.out_ready   (rsp.ready),
		.tx_byte     (rsp.tx_byte),
		.tx_last     (rsp.tx_last),
		.regs_written(rsp.regs_written)
	);

endmodule

`default_nettype wire

@@ rtl/mrs_checker.sv @@
// ----------------------------------------------------------------------------
// mrs_checker
// Port-level checks of the responder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mrs_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       req_valid,
	input wire logic       req_ready,
	input wire logic       rsp_valid,
	input wire logic       rsp_ready,
	input wire logic [7:0] tx_byte,
	input wire logic       tx_last,
	input wire logic       regs_written
);

	// A stalled beat holds its byte
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(tx_byte))
		else $error("response beat changed while stalled");

	// No request is taken while a response is still in flight
	a_no_req_mid_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !tx_last |-> !req_ready)
		else $error("request taken during response");

	// No request beat is accepted next to a non-final response beat
	a_no_req_beat_mid: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !tx_last |-> !(req_valid && req_ready))
		else $error("request beat accepted during response");

	// The write flag is the same on every beat of one response
	a_flag_steady: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready && !tx_last |=>
		!rsp_valid || (regs_written == $past(regs_written)))
		else $error("regs_written changed inside a response");

endmodule

bind modbus_rtu_slave_responder_top mrs_checker u_mrs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.tx_byte     (rsp.tx_byte),
	.tx_last     (rsp.tx_last),
	.regs_written(rsp.regs_written)
);

`default_nettype wire
